// ===== hw/rtl/sst_pkg.sv =====
// Package for the sorted set table: operation codes, control state, the
// per-cell control struct and the fixed field widths. No dependencies.
package sst_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned COUNT_O_W  = 7;

  // Default number of entries
  localparam int unsigned SST_CAPACITY = 64;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_RMIN     = 3'd3,
    OP_RMAX     = 3'd4
  } opcode_t;

  // Control sequence of one item
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APP,
    ST_OUT
  } state_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic cmp;   // capture compare flags against the key
    logic ins;   // open a slot at the key's place and write the key
    logic del;   // close the gap at the matching entry
    logic pop;   // shift everything down by one
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sst_cell.sv =====
// One cell of the sorted table: holds one entry, compares it with the key
// and shifts up or down with its neighbors. Depends on sst_pkg.
module sst_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sst_pkg::cell_ctl_t                ctl,
  input  logic signed [sst_pkg::VALUE_W-1:0] key,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [sst_pkg::VALUE_W-1:0] prev_val,
  input  logic                              prev_le,
  input  logic signed [sst_pkg::VALUE_W-1:0] next_val,
  output logic signed [sst_pkg::VALUE_W-1:0] val,
  output logic                              le,
  output logic                              eq,
  output logic signed [sst_pkg::VALUE_W-1:0] tail_val
);

  logic signed [sst_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic le_r, eq_r;
  logic valid;

  // Entry is live while its index is below the count
  assign valid = CNT_W'(IDX) < count;

  // Compare flags, captured once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      le_r <= valid && (val_r <= key);
      eq_r <= valid && (val_r == key);
    end
  end

  // Shift network: insert opens a slot above the entries <= key
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!le_r) begin
        val_nxt = prev_le ? key : prev_val;
      end
    end else if (ctl.del) begin
      if (!le_r || eq_r) begin
        val_nxt = next_val;
      end
    end else if (ctl.pop) begin
      val_nxt = next_val;
    end
  end

  // Entry storage, no reset: read only after written
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign le       = le_r;
  assign eq       = eq_r;
  assign tail_val = (CNT_W'(IDX + 1) == count) ? val_r : '0;

endmodule

// ===== hw/rtl/sorted_set_table_core.sv =====
// Top level of the sorted set table: item handshake, control sequence,
// count register and the chain of sst_cell entries. Depends on sst_pkg.
//
// Holds up to CAPACITY distinct signed 32-bit values in ascending order, one
// per cell. Each item is an operation (in_tuser) on a value (in_tdata); each
// item gives exactly one result with the prior presence, the full status, the
// count and the smallest and largest entries afterwards (0 when empty).
// An item passes through the steps of the control sequence in order: accept,
// compare in all cells against the key in parallel, shift the chain in or out,
// and load the result register. A result still waiting in the result register
// holds the sequence in its load step until out_tready frees the register. One
// item is in work at a time; the result register holds its item while the next
// one is accepted. After reset the set is empty and no clearing pass is needed.
module sorted_set_table_core #(
  parameter int unsigned CAPACITY = sst_pkg::SST_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [7:0]  in_tuser,   // [2:0] opcode, rest zero
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [0] was_present, [1] status, [8:2] count,
                                  // [40:9] smallest, [72:41] largest,
                                  // [73] nonempty, rest zero
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VW    = sst_pkg::VALUE_W;

  sst_pkg::state_t    state_r, state_nxt;
  sst_pkg::cell_ctl_t ctl;

  logic [sst_pkg::OPCODE_W-1:0] op_r;
  logic signed [VW-1:0]         key_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         pres_r, pres_nxt;
  logic                         stat_r, stat_nxt;
  logic                         out_valid_r;
  logic [79:0]                  out_data_r;

  logic signed [VW-1:0] cell_val  [CAPACITY];
  logic signed [VW-1:0] cell_tail [CAPACITY];
  logic [CAPACITY-1:0]  cell_le;
  logic [CAPACITY-1:0]  cell_eq;

  logic                 found;
  logic                 full;
  logic                 in_acc;
  logic                 out_free;
  logic signed [VW-1:0] largest;
  logic signed [VW-1:0] smallest;
  logic [CNT_W+sst_pkg::COUNT_O_W-1:0] count_ext;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign found    = |cell_eq;
  assign full     = count_r == CNT_W'(CAPACITY);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sst_pkg::ST_IDLE: if (in_tvalid) state_nxt = sst_pkg::ST_CMP;
      sst_pkg::ST_CMP:  state_nxt = sst_pkg::ST_APP;
      sst_pkg::ST_APP:  state_nxt = sst_pkg::ST_OUT;
      sst_pkg::ST_OUT:  if (out_free) state_nxt = sst_pkg::ST_IDLE;
      default:          state_nxt = sst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell control, count, flags and in_tready
  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    pres_nxt  = pres_r;
    stat_nxt  = stat_r;
    in_tready = 1'b0;
    unique case (state_r)
      sst_pkg::ST_IDLE: in_tready = 1'b1;
      sst_pkg::ST_CMP:  ctl.cmp = 1'b1;
      sst_pkg::ST_APP: begin
        pres_nxt = 1'b0;
        stat_nxt = 1'b0;
        unique case (op_r)
          sst_pkg::OP_ADD: begin
            pres_nxt = found;
            if (!found) begin
              if (full) begin
                stat_nxt = 1'b1;
              end else begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
          end
          sst_pkg::OP_REMOVE: begin
            pres_nxt = found;
            if (found) begin
              ctl.del   = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          sst_pkg::OP_CONTAINS: pres_nxt = found;
          sst_pkg::OP_RMIN: begin
            if (count_r != '0) begin
              pres_nxt  = 1'b1;
              ctl.pop   = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          sst_pkg::OP_RMAX: begin
            if (count_r != '0) begin
              pres_nxt  = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
      sst_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::ST_IDLE;
      count_r <= '0;
      pres_r  <= 1'b0;
      stat_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pres_r  <= pres_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser[sst_pkg::OPCODE_W-1:0];
      key_r <= in_tdata[VW-1:0];
    end
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VW-1:0] prev_v, next_v;
    logic                 prev_l;
    if (i == 0) begin : g_head
      assign prev_v = key_r;
      assign prev_l = 1'b1;
    end else begin : g_body
      assign prev_v = cell_val[i-1];
      assign prev_l = cell_le[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_v = '0;
    end else begin : g_next
      assign next_v = cell_val[i+1];
    end
    sst_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .key      (key_r),
      .count    (count_r),
      .prev_val (prev_v),
      .prev_le  (prev_l),
      .next_val (next_v),
      .val      (cell_val[i]),
      .le       (cell_le[i]),
      .eq       (cell_eq[i]),
      .tail_val (cell_tail[i])
    );
  end

  // Largest: only the tail cell drives a nonzero word
  always_comb begin
    largest = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest = largest | cell_tail[i];
    end
  end

  assign smallest  = (count_r != '0) ? cell_val[0] : '0;
  assign count_ext = {{sst_pkg::COUNT_O_W{1'b0}}, count_r};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sst_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sst_pkg::ST_OUT && out_free) begin
      out_data_r <= {6'b0, (count_r != '0), largest, smallest,
                     count_ext[sst_pkg::COUNT_O_W-1:0], stat_r, pres_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/sst_checker.sv =====
// Port-level checks for the sorted set table, attached to
// sorted_set_table_core by the bind below. Depends on the top level's ports.
module sst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Empty set reports zero bounds
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[73] |-> out_tdata[40:9] == 32'd0 && out_tdata[72:41] == 32'd0)
    else $error("empty set with nonzero bounds");

  // Bounds are ordered
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[73] |-> $signed(out_tdata[40:9]) <= $signed(out_tdata[72:41]))
    else $error("smallest above largest");

  // A full rejection only happens for an absent value
  a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("full status with value present");

  // One item in work: no acceptance in the cycle after one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

endmodule

bind sorted_set_table_core sst_checker u_sst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
